### hdl/mlbc_pkg.sv
// mlbc_pkg: opcodes, status codes and constants of the multi-LED blink controller
// no dependencies; imported by the channel interfaces and the top level

package mlbc_pkg;

  // command opcodes carried on the input channel
  typedef enum logic [2:0] {
    OP_ON          = 3'd0,
    OP_MASK_ON     = 3'd1,
    OP_OFF         = 3'd2,
    OP_MASK_OFF    = 3'd3,
    OP_BLINK_START = 3'd4,
    OP_BLINK_STOP  = 3'd5,
    OP_SET_PERIOD  = 3'd6,
    OP_TICK        = 3'd7
  } opcode_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NODEV      = 3'd1,
    ST_BLINKING   = 3'd2,
    ST_ZEROMASK   = 3'd3,
    ST_BLINKSTATE = 3'd4
  } status_t;

  // field widths
  localparam int IDX_W    = 8;
  localparam int MASK_W   = 8;
  localparam int MS_W     = 16;
  localparam int PERIOD_W = 10;
  localparam int OUT_LEDS = 8;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_LEDS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH = 1'b1;
  localparam logic [3:0] NUM_LEDS_RST    = 4'd8;
  localparam logic [7:0] ACTIVE_HIGH_RST = 8'hff;

  // blink period: clamp in ms, then ms / 10 by reciprocal multiply
  localparam int CLAMP_W = 14;
  localparam int PROD_W  = 26;
  localparam logic [MS_W-1:0]     PERIOD_MS_MIN  = 16'd10;
  localparam logic [MS_W-1:0]     PERIOD_MS_MAX  = 16'd10000;
  localparam logic [PROD_W-1:0]   DIV10_MUL      = 26'd6554;
  localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = 10'd50;

endpackage

### hdl/mlbc_cmd_if.sv
// mlbc_cmd_if: valid/ready command channel of the multi-LED blink controller
// depends on mlbc_pkg for the opcode type and field widths

interface mlbc_cmd_if import mlbc_pkg::*; ();
  logic              valid;
  logic              ready;
  opcode_t           opcode;
  logic [IDX_W-1:0]  led_index;
  logic [MASK_W-1:0] led_mask;
  logic [MS_W-1:0]   timeout_ms;

  modport source (output valid, output opcode, output led_index, output led_mask,
                  output timeout_ms, input ready);
  modport sink   (input valid, input opcode, input led_index, input led_mask,
                  input timeout_ms, output ready);
endinterface

### hdl/mlbc_res_if.sv
// mlbc_res_if: valid/ready result channel of the multi-LED blink controller
// depends on mlbc_pkg for the status type and field widths

interface mlbc_res_if import mlbc_pkg::*; ();
  logic                valid;
  logic                ready;
  status_t             status;
  logic [OUT_LEDS-1:0] pin_levels;
  logic [OUT_LEDS-1:0] blinking_mask;

  modport source (output valid, output status, output pin_levels, output blinking_mask,
                  input ready);
  modport sink   (input valid, input status, input pin_levels, input blinking_mask,
                  output ready);
endinterface

### hdl/multi_led_blink_controller.sv
// multi_led_blink_controller: top level, one lane of LED state per LED
// depends on mlbc_pkg, mlbc_cmd_if and mlbc_res_if

// Drives NUM_LEDS LED pins, polarity programmable for LEDs 0..7. Every command
// beat (on, off, mask on, mask off, blink start, blink stop, set period, tick)
// returns exactly one result beat carrying a status, the pin levels of LEDs 0..7
// and the blinking mask of LEDs 0..7. A command beat is captured in an input
// register, all LED lanes evaluate it in parallel while it is held there, and
// the result lands in an output register when the input stage advances; a new
// command can be taken every cycle as long as the result side keeps draining.
// The input and output registers hold one beat each, so with the result
// channel stalled the command channel takes at most one more beat and then
// drops ready for as long as the stall lasts. Mask commands walk LEDs upward
// and stop at the first blinking LED, leaving lower LEDs switched. Blink
// periods are clamped to 10..10000 ms and kept in 10 ms ticks; each tick beat
// counts every blinking LED down and toggles it on expiry. Configuration
// (num_leds, active_high_mask) must be written through the cfg_ port only
// while no command is in flight; the block does not enforce this. A polarity
// change does not re-drive any pin.

module multi_led_blink_controller import mlbc_pkg::*; #(
  parameter int NUM_LEDS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mlbc_cmd_if.sink              in_ch,
  mlbc_res_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // LEDs visible on the result fields and reachable by mask commands
  localparam int VIS = (NUM_LEDS < OUT_LEDS) ? NUM_LEDS : OUT_LEDS;
  localparam logic [IDX_W-1:0] NUM_LEDS_IDX = IDX_W'(NUM_LEDS);

  // configuration registers
  logic [3:0] num_leds_r;
  logic [7:0] active_high_r;

  // per-LED lane state
  logic [NUM_LEDS-1:0] pin_r,    pin_nxt;
  logic [NUM_LEDS-1:0] active_r, active_nxt;
  logic [NUM_LEDS-1:0] phase_r,  phase_nxt;
  logic [PERIOD_W-1:0] period_r    [NUM_LEDS];
  logic [PERIOD_W-1:0] period_nxt  [NUM_LEDS];
  logic [PERIOD_W-1:0] countdn_r   [NUM_LEDS];
  logic [PERIOD_W-1:0] countdn_nxt [NUM_LEDS];

  // input register
  logic              s1_valid_r;
  opcode_t           s1_op_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic [MASK_W-1:0] s1_mask_r;
  logic [MS_W-1:0]   s1_ms_r;

  // output register
  logic                out_valid_r;
  status_t             out_status_r,  out_status_nxt;
  logic [OUT_LEDS-1:0] out_pins_r,    out_pins_nxt;
  logic [OUT_LEDS-1:0] out_blink_r,   out_blink_nxt;

  logic advance;

  // the input stage moves on when the output register is free or being drained
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.pin_levels    = out_pins_r;
  assign out_ch.blinking_mask = out_blink_r;

  // ---------------------------------------------------------------------------
  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_leds_r    <= NUM_LEDS_RST;
      active_high_r <= ACTIVE_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_LEDS:    num_leds_r    <= cfg_wdata[3:0];
        CFG_ACTIVE_HIGH: active_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // command decode and lane update
  logic [IDX_W-1:0]    eff_cnt;
  logic [IDX_W-1:0]    num_leds_ext;
  logic                single_op;
  logic                no_dev;
  logic [NUM_LEDS-1:0] sel_vec;
  logic [NUM_LEDS-1:0] ah_vec;
  logic [NUM_LEDS-1:0] mask_vec;
  logic [NUM_LEDS-1:0] apply_vec;
  logic                sel_active;
  logic                blocked;
  logic                op_on;
  logic [CLAMP_W-1:0]  ms_clamped;
  logic [PROD_W-1:0]   div_prod;
  logic [PERIOD_W-1:0] new_period;

  assign num_leds_ext = IDX_W'(num_leds_r);
  assign eff_cnt      = (num_leds_ext < NUM_LEDS_IDX) ? num_leds_ext : NUM_LEDS_IDX;

  assign single_op = (s1_op_r == OP_ON) || (s1_op_r == OP_OFF) ||
                     (s1_op_r == OP_BLINK_START) || (s1_op_r == OP_BLINK_STOP) ||
                     (s1_op_r == OP_SET_PERIOD);
  assign no_dev    = single_op && (s1_idx_r >= eff_cnt);
  assign op_on     = (s1_op_r == OP_ON) || (s1_op_r == OP_MASK_ON);

  // clamp to 10..10000 ms, then divide by 10 (6554 / 2^16, exact over this range)
  always_comb begin
    if (s1_ms_r < PERIOD_MS_MIN) begin
      ms_clamped = CLAMP_W'(PERIOD_MS_MIN);
    end else if (s1_ms_r > PERIOD_MS_MAX) begin
      ms_clamped = CLAMP_W'(PERIOD_MS_MAX);
    end else begin
      ms_clamped = s1_ms_r[CLAMP_W-1:0];
    end
  end
  assign div_prod   = PROD_W'(ms_clamped) * DIV10_MUL;
  assign new_period = div_prod[PROD_W-1:16];

  // lane select, polarity and mask vectors
  always_comb begin
    ah_vec   = '1;
    mask_vec = '0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      sel_vec[i] = (s1_idx_r == IDX_W'(i));
    end
    for (int i = 0; i < VIS; i++) begin
      ah_vec[i]   = active_high_r[i];
      mask_vec[i] = s1_mask_r[i] && (IDX_W'(i) < eff_cnt);
    end
  end

  assign sel_active = |(active_r & sel_vec);

  // mask walk: masked lanes below the first blinking lane in the mask get switched
  always_comb begin
    blocked   = 1'b0;
    apply_vec = '0;
    for (int i = 0; i < VIS; i++) begin
      apply_vec[i] = mask_vec[i] && !active_r[i] && !blocked;
      blocked      = blocked || (mask_vec[i] && active_r[i]);
    end
  end

  always_comb begin
    pin_nxt        = pin_r;
    active_nxt     = active_r;
    phase_nxt      = phase_r;
    period_nxt     = period_r;
    countdn_nxt    = countdn_r;
    out_status_nxt = ST_OK;

    if (no_dev) begin
      out_status_nxt = ST_NODEV;
    end else begin
      unique case (s1_op_r)
        OP_ON, OP_OFF: begin
          if (sel_active) begin
            out_status_nxt = ST_BLINKING;
          end else begin
            for (int i = 0; i < NUM_LEDS; i++) begin
              if (sel_vec[i]) pin_nxt[i] = op_on ~^ ah_vec[i];
            end
          end
        end
        OP_MASK_ON, OP_MASK_OFF: begin
          if (s1_mask_r == '0) begin
            out_status_nxt = ST_ZEROMASK;
          end else begin
            if (blocked) out_status_nxt = ST_BLINKING;
            for (int i = 0; i < NUM_LEDS; i++) begin
              if (apply_vec[i]) pin_nxt[i] = op_on ~^ ah_vec[i];
            end
          end
        end
        OP_BLINK_START: begin
          if (sel_active) begin
            out_status_nxt = ST_BLINKSTATE;
          end else begin
            active_nxt = active_r | sel_vec;
            for (int i = 0; i < NUM_LEDS; i++) begin
              if (sel_vec[i]) countdn_nxt[i] = period_r[i];
            end
          end
        end
        OP_BLINK_STOP: begin
          if (!sel_active) begin
            out_status_nxt = ST_BLINKSTATE;
          end else begin
            active_nxt = active_r & ~sel_vec;
          end
        end
        OP_SET_PERIOD: begin
          for (int i = 0; i < NUM_LEDS; i++) begin
            if (sel_vec[i]) period_nxt[i] = new_period;
          end
        end
        OP_TICK: begin
          // every blinking lane counts down; a count of 0 or 1 expires
          for (int i = 0; i < NUM_LEDS; i++) begin
            if (active_r[i]) begin
              if (countdn_r[i] <= PERIOD_W'(1)) begin
                phase_nxt[i]   = !phase_r[i];
                pin_nxt[i]     = !phase_r[i] ~^ ah_vec[i];
                countdn_nxt[i] = period_r[i];
              end else begin
                countdn_nxt[i] = countdn_r[i] - PERIOD_W'(1);
              end
            end
          end
        end
      endcase
    end

    out_pins_nxt  = '0;
    out_blink_nxt = '0;
    for (int i = 0; i < VIS; i++) begin
      out_pins_nxt[i]  = pin_nxt[i];
      out_blink_nxt[i] = active_nxt[i];
    end
  end

  // ---------------------------------------------------------------------------
  // lane state, committed when the command leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r    <= '0;
      active_r <= '0;
      phase_r  <= '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        period_r[i]  <= DEFAULT_PERIOD;
        countdn_r[i] <= '0;
      end
    end else if (advance) begin
      pin_r     <= pin_nxt;
      active_r  <= active_nxt;
      phase_r   <= phase_nxt;
      period_r  <= period_nxt;
      countdn_r <= countdn_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_op_r   <= in_ch.opcode;
      s1_idx_r  <= in_ch.led_index;
      s1_mask_r <= in_ch.led_mask;
      s1_ms_r   <= in_ch.timeout_ms;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= out_status_nxt;
      out_pins_r   <= out_pins_nxt;
      out_blink_r  <= out_blink_nxt;
    end
  end

endmodule

### dv/mlbc_tb_pkg.sv
// mlbc_tb_pkg: scoreboard for the multi-LED blink controller testbench
// keeps its own copy of the LED lanes and checks result beats in order
// depends on mlbc_pkg for opcodes, status codes and widths
`timescale 1ns / 1ps

package mlbc_tb_pkg;
  import mlbc_pkg::*;

  typedef struct packed {
    status_t             status;
    logic [OUT_LEDS-1:0] pin_levels;
    logic [OUT_LEDS-1:0] blinking_mask;
  } led_snapshot_t;

  class blink_scoreboard;
    bit [3:0]          num_leds;
    bit [7:0]          active_high;
    bit                level[OUT_LEDS];
    bit                blinking[OUT_LEDS];
    bit                phase[OUT_LEDS];
    bit [PERIOD_W-1:0] period[OUT_LEDS];
    bit [PERIOD_W-1:0] countdown[OUT_LEDS];
    led_snapshot_t     due_snapshots[$];
    int                errors;

    function new();
      num_leds    = NUM_LEDS_RST;
      active_high = ACTIVE_HIGH_RST;
      errors      = 0;
      for (int i = 0; i < OUT_LEDS; i++) begin
        level[i]     = 1'b0;
        blinking[i]  = 1'b0;
        phase[i]     = 1'b0;
        period[i]    = DEFAULT_PERIOD;
        countdown[i] = '0;
      end
    endfunction

    function void set_config(bit [3:0] count, bit [7:0] polarity);
      num_leds    = count;
      active_high = polarity;
    endfunction

    function int present_leds();
      return (num_leds < OUT_LEDS) ? int'(num_leds) : OUT_LEDS;
    endfunction

    function int pending();
      return due_snapshots.size();
    endfunction

    function void light(int i, bit on);
      level[i] = active_high[i] ? on : !on;
    endfunction

    // walk upward, stop at the first blinking LED in the mask
    function status_t sweep_mask(bit [7:0] mask, bit on);
      if (mask == '0)
        return ST_ZEROMASK;
      for (int i = 0; i < present_leds(); i++) begin
        if (mask[i]) begin
          if (blinking[i])
            return ST_BLINKING;
          light(i, on);
        end
      end
      return ST_OK;
    endfunction

    function void note_command(opcode_t op, bit [7:0] idx, bit [7:0] mask, bit [15:0] ms);
      status_t       st;
      bit            single;
      int            clamped;
      led_snapshot_t snap;
      st     = ST_OK;
      single = (op == OP_ON || op == OP_OFF || op == OP_BLINK_START ||
                op == OP_BLINK_STOP || op == OP_SET_PERIOD);
      if (single && int'(idx) >= present_leds()) begin
        st = ST_NODEV;
      end else begin
        case (op)
          OP_ON, OP_OFF: begin
            if (blinking[idx])
              st = ST_BLINKING;
            else
              light(idx, op == OP_ON);
          end
          OP_MASK_ON:  st = sweep_mask(mask, 1'b1);
          OP_MASK_OFF: st = sweep_mask(mask, 1'b0);
          OP_BLINK_START: begin
            if (blinking[idx]) begin
              st = ST_BLINKSTATE;
            end else begin
              blinking[idx]  = 1'b1;
              countdown[idx] = period[idx];
            end
          end
          OP_BLINK_STOP: begin
            if (!blinking[idx])
              st = ST_BLINKSTATE;
            else
              blinking[idx] = 1'b0;
          end
          OP_SET_PERIOD: begin
            clamped = ms;
            if (clamped < PERIOD_MS_MIN)
              clamped = PERIOD_MS_MIN;
            else if (clamped > PERIOD_MS_MAX)
              clamped = PERIOD_MS_MAX;
            period[idx] = PERIOD_W'(clamped / 10);
          end
          default: begin
            for (int i = 0; i < OUT_LEDS; i++) begin
              if (blinking[i]) begin
                if (countdown[i] <= 1) begin
                  phase[i] = !phase[i];
                  light(i, phase[i]);
                  countdown[i] = period[i];
                end else begin
                  countdown[i] = countdown[i] - 1'b1;
                end
              end
            end
          end
        endcase
      end
      snap.status = st;
      for (int i = 0; i < OUT_LEDS; i++) begin
        snap.pin_levels[i]    = level[i];
        snap.blinking_mask[i] = blinking[i];
      end
      due_snapshots.push_back(snap);
    endfunction

    function void check_result(status_t st, logic [7:0] pins, logic [7:0] blink);
      led_snapshot_t exp;
      if (due_snapshots.size() == 0) begin
        $error("result beat with no command outstanding");
        errors++;
        return;
      end
      exp = due_snapshots.pop_front();
      if (st !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, st);
        errors++;
      end
      if (pins !== exp.pin_levels) begin
        $error("pin_levels: expected %02h, got %02h", exp.pin_levels, pins);
        errors++;
      end
      if (blink !== exp.blinking_mask) begin
        $error("blinking_mask: expected %02h, got %02h", exp.blinking_mask, blink);
        errors++;
      end
    endfunction
  endclass

endpackage

### dv/tb_top.sv
// tb_top: self-checking testbench of multi_led_blink_controller
// directed commands, then random command streams across several LED configurations
// depends on mlbc_pkg, mlbc_cmd_if, mlbc_res_if, mlbc_tb_pkg and the DUT
`timescale 1ns / 1ps

module tb_top;
  import mlbc_pkg::*;
  import mlbc_tb_pkg::*;

  localparam int LIMIT_CYCLES   = 400000;
  localparam int BEATS_PER_PASS = 95;
  localparam int NUM_PASSES     = 7;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    cycles = 0;
  bit                    quiet = 1'b0;  // no gaps or stalls on either side

  mlbc_cmd_if in_ch();
  mlbc_res_if out_ch();

  blink_scoreboard sb = new();

  multi_led_blink_controller DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL multi_led_blink_controller");
      $finish;
    end
  end

  // both channels sampled at the edge, so values are the ones the handshake saw
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_command(in_ch.opcode, in_ch.led_index, in_ch.led_mask, in_ch.timeout_ms);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.status, out_ch.pin_levels, out_ch.blinking_mask);
  end

  // result side: runs of ready with random stalls in between
  initial begin
    int run;
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      run = $urandom_range(1, 20);
      repeat (run) @(posedge clk);
      if (!quiet && $urandom_range(0, 99) < 50) begin
        out_ch.ready <= 1'b0;
        stall = gap_len();
        repeat (stall) @(posedge clk);
      end
    end
  end

  // one command beat; valid stays high when the next beat follows at once
  task automatic send_cmd(opcode_t op, logic [7:0] idx, logic [7:0] mask, logic [15:0] ms);
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.led_index  <= idx;
    in_ch.led_mask   <= mask;
    in_ch.timeout_ms <= ms;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (!quiet && $urandom_range(0, 99) < 40) begin
      in_ch.valid <= 1'b0;
      gap = gap_len();
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain all outstanding results; only called right after an accepted beat
  task automatic drain();
    in_ch.valid <= 1'b0;
    // let the monitor log the last accepted beat before looking at the queue
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    // the pipeline is empty by now; give it a little extra before touching the config
    repeat (4) @(posedge clk);
  endtask

  // write both registers, upper nibble of the LED count is junk on purpose
  task automatic program_leds(logic [3:0] count, logic [7:0] polarity);
    logic [3:0] junk;
    junk = 4'($urandom());
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NUM_LEDS;
    cfg_wdata <= {junk, count};
    @(posedge clk);
    cfg_index <= CFG_ACTIVE_HIGH;
    cfg_wdata <= polarity;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(count, polarity);
  endtask

  // random command: ticks dominate so blinking LEDs actually toggle
  task automatic random_cmd();
    opcode_t     op;
    logic [7:0]  idx;
    logic [7:0]  mask;
    logic [15:0] ms;
    int          r;
    int          top;
    r = $urandom_range(0, 99);
    if (r < 30)      op = OP_TICK;
    else if (r < 40) op = OP_SET_PERIOD;
    else if (r < 50) op = OP_BLINK_START;
    else if (r < 58) op = OP_BLINK_STOP;
    else if (r < 66) op = OP_ON;
    else if (r < 74) op = OP_OFF;
    else if (r < 87) op = OP_MASK_ON;
    else             op = OP_MASK_OFF;
    // mostly present LEDs, some just past the end, a few anywhere
    top = (sb.present_leds() > 0) ? sb.present_leds() - 1 : 0;
    r = $urandom_range(0, 99);
    if (r < 75)      idx = 8'($urandom_range(0, top));
    else if (r < 90) idx = 8'($urandom_range(0, 9));
    else             idx = 8'($urandom());
    mask = ($urandom_range(0, 99) < 5) ? 8'h00 : 8'($urandom());
    // short periods so expiries happen often, plus the full clamp range
    r = $urandom_range(0, 99);
    if (r < 70)      ms = 16'($urandom_range(0, 60));
    else if (r < 85) ms = 16'($urandom_range(9990, 10020));
    else             ms = 16'($urandom());
    send_cmd(op, idx, mask, ms);
  endtask

  initial begin
    logic [3:0] count;
    logic [7:0] polarity;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_TICK;
    in_ch.led_index  <= '0;
    in_ch.led_mask   <= '0;
    in_ch.timeout_ms <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_NUM_LEDS;
    cfg_wdata        <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass at reset config: eight LEDs, all active high
    send_cmd(OP_ON, 8'd0, 8'h00, 16'd0);
    send_cmd(OP_ON, 8'd7, 8'h00, 16'd0);
    send_cmd(OP_ON, 8'd8, 8'h00, 16'd0);             // first index past the end
    send_cmd(OP_OFF, 8'd255, 8'hff, 16'hffff);       // far out of range
    send_cmd(OP_MASK_ON, 8'd0, 8'h00, 16'd0);        // empty mask
    send_cmd(OP_MASK_OFF, 8'd0, 8'hff, 16'd0);
    send_cmd(OP_SET_PERIOD, 8'd0, 8'h00, 16'd0);     // clamps up to one tick
    send_cmd(OP_SET_PERIOD, 8'd1, 8'h00, 16'hffff);  // clamps down to 1000 ticks
    send_cmd(OP_SET_PERIOD, 8'd2, 8'h00, 16'd19);    // truncates to one tick
    send_cmd(OP_BLINK_START, 8'd0, 8'h00, 16'd0);
    send_cmd(OP_BLINK_START, 8'd0, 8'h00, 16'd0);    // already blinking
    send_cmd(OP_BLINK_STOP, 8'd3, 8'h00, 16'd0);     // not blinking
    send_cmd(OP_ON, 8'd0, 8'h00, 16'd0);             // refused while blinking
    send_cmd(OP_TICK, 8'd0, 8'h00, 16'd0);
    send_cmd(OP_TICK, 8'd0, 8'h00, 16'd0);
    send_cmd(OP_BLINK_STOP, 8'd0, 8'h00, 16'd0);     // pin holds its level
    send_cmd(OP_BLINK_START, 8'd4, 8'h00, 16'd0);
    send_cmd(OP_MASK_ON, 8'd0, 8'hff, 16'd0);        // lower LEDs switch, stops at 4
    send_cmd(OP_SET_PERIOD, 8'd4, 8'h00, 16'd30);    // new period on next reload
    send_cmd(OP_TICK, 8'd0, 8'h00, 16'd0);
    send_cmd(OP_BLINK_STOP, 8'd4, 8'h00, 16'd0);
    send_cmd(OP_MASK_OFF, 8'd0, 8'ha5, 16'd0);
    send_cmd(OP_SET_PERIOD, 8'd7, 8'h00, 16'd10);
    send_cmd(OP_SET_PERIOD, 8'd6, 8'h00, 16'd10000);
    send_cmd(OP_SET_PERIOD, 8'd5, 8'h00, 16'd10001);

    for (int pass = 0; pass < NUM_PASSES; pass++) begin
      if (pass > 0) begin
        drain();
        case (pass)
          1: begin count = 4'd0;  polarity = 8'h00; end
          2: begin count = 4'd8;  polarity = 8'h00; end
          3: begin count = 4'd3;  polarity = 8'ha5; end
          4: begin count = 4'd15; polarity = 8'hff; end
          5: begin count = 4'd5;  polarity = 8'($urandom()); end
          default: begin
            count    = 4'($urandom_range(0, 15));
            polarity = 8'($urandom());
          end
        endcase
        program_leds(count, polarity);
        // mask that only covers absent LEDs: no change, status ok
        if (sb.present_leds() < OUT_LEDS)
          send_cmd(OP_MASK_ON, 8'd0, 8'hff << sb.present_leds(), 16'd0);
      end
      quiet = (pass == 2 || pass == 5);
      repeat (BEATS_PER_PASS) random_cmd();
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASS multi_led_blink_controller");
    else
      $display("FAIL multi_led_blink_controller");
    $finish;
  end

endmodule

### sim.f
hdl/mlbc_pkg.sv
hdl/mlbc_cmd_if.sv
hdl/mlbc_res_if.sv
hdl/multi_led_blink_controller.sv
dv/mlbc_tb_pkg.sv
dv/tb_top.sv
